@@ rtl/core/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// types and codes shared by the circular deque modules
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int unsigned DATA_W = 32;

	// operation codes of a request beat
	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_REAR  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_REAR   = 2'd3
	} kind_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef logic signed [DATA_W-1:0] word_t;

	// per-operation outcome handed from the controller to the response stage
	typedef struct packed {
		status_t status;
		logic    pop;
	} res_t;

endpackage

@@ rtl/core/cdq_if.sv @@
// ----------------------------------------------------------------------------
// cdq request and response channels
// valid/ready channels carrying deque operations and their outcomes
// ----------------------------------------------------------------------------
interface cdq_req_if import cdq_pkg::*; ();
	logic  valid;
	logic  ready;
	kind_t kind;
	word_t push_value;

	modport source (output valid, output kind, output push_value, input ready);
	modport sink (input valid, input kind, input push_value, output ready);
endinterface

interface cdq_rsp_if import cdq_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	word_t   pop_value;
	logic    pop_valid;

	modport source (output valid, output status, output pop_value, output pop_valid,
		input ready);
	modport sink (input valid, input status, input pop_value, input pop_valid,
		output ready);
endinterface

@@ rtl/core/circular_deque_core.sv @@
// ----------------------------------------------------------------------------
// circular_deque_core
// fixed-depth circular double-ended queue of 32-bit words held in a ram
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | beat
//  --------+-----+---------------------------------+--------------------------
//  req     | in  | kind, push_value                | one deque operation
//  rsp     | out | status, pop_value, pop_valid    | one outcome per req beat
//
// one req beat per cycle while req.ready is high; its rsp beat appears in the
// cycle after acceptance, when the registered ram read of a pop has returned
// pointers and the empty flag live in flops beside the ram; every operation
// touches at most one ram entry, so no two accesses ever overlap
// reset clears pointers, empty flag and the response valid flag; the ram is not
// cleared, since only occupied (written) entries are ever read
// req.ready drops while a response is held and rsp.ready is low; the ram
// read data then holds because no new read is issued
module circular_deque_core import cdq_pkg::*; #(
	parameter int unsigned DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	cdq_req_if.sink    req,
	cdq_rsp_if.source  rsp
);

	localparam int unsigned PTR_W = $clog2(DEPTH);

	logic             acc;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_addr;
	word_t            ram_wdata, ram_rdata;
	res_t             res, res_s1;
	logic             valid_s1;

	// accept whenever the response stage is free or drains this cycle
	assign req.ready = !valid_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;

	cdq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.kind       (req.kind),
		.push_value (req.push_value),
		.ram_we     (ram_we),
		.ram_re     (ram_re),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.res        (res)
	);

	// ring storage
	cdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// response stage, lines up with the ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res;
		end
	end

	assign rsp.valid     = valid_s1;
	assign rsp.status    = res_s1.status;
	assign rsp.pop_valid = res_s1.pop;
	// pushes and refused pops report a zero word
	assign rsp.pop_value = res_s1.pop ? ram_rdata : '0;

endmodule

@@ rtl/core/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

@@ rtl/core/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdq_ctrl
// head/tail pointers, empty flag and ram access decision per operation
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc,
	input  kind_t                    kind,
	input  word_t                    push_value,
	output logic                     ram_we,
	output logic                     ram_re,
	output logic [$clog2(DEPTH)-1:0] ram_addr,
	output word_t                    ram_wdata,
	output res_t                     res
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic             empty_q, empty_d;
	logic             wr, rd, full;
	logic [PTR_W-1:0] tail_inc, tail_dec, head_inc, head_dec;

	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? PTR_LAST : head_q - 1'b1;
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
	assign full     = !empty_q && (head_q == tail_inc);

	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		empty_d    = empty_q;
		wr         = 1'b0;
		rd         = 1'b0;
		ram_addr   = '0;
		res.status = ST_OK;
		res.pop    = 1'b0;
		unique case (kind) inside
			KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
				if (empty_q) begin
					// first element always lands at entry zero
					head_d  = '0;
					tail_d  = '0;
					empty_d = 1'b0;
					wr      = 1'b1;
				end else if (full) begin
					res.status = ST_FULL;
				end else if (kind == KIND_PUSH_FRONT) begin
					head_d   = head_dec;
					ram_addr = head_dec;
					wr       = 1'b1;
				end else begin
					tail_d   = tail_inc;
					ram_addr = tail_inc;
					wr       = 1'b1;
				end
			end
			KIND_POP_FRONT, KIND_POP_REAR: begin
				if (empty_q) begin
					res.status = ST_EMPTY;
				end else begin
					ram_addr = (kind == KIND_POP_FRONT) ? head_q : tail_q;
					rd       = 1'b1;
					res.pop  = 1'b1;
					if (head_q == tail_q) begin
						// last element leaves, pointers go home
						empty_d = 1'b1;
						head_d  = '0;
						tail_d  = '0;
					end else if (kind == KIND_POP_FRONT) begin
						head_d = head_inc;
					end else begin
						tail_d = tail_dec;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we    = acc && wr;
	assign ram_re    = acc && rd;
	assign ram_wdata = push_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (acc) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			empty_q <= empty_d;
		end
	end

endmodule
